FILE: sv/stereo_meter_ballistics_peak_hold_top_assert.svh
// assertion macros for the stereo meter ballistics block
`ifndef STEREO_METER_BALLISTICS_PEAK_HOLD_TOP_ASSERT_SVH
`define STEREO_METER_BALLISTICS_PEAK_HOLD_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// property checked at every clock edge outside reset
`define SMB_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// property checked at every clock edge, reset included
`define SMB_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`else

`define SMB_ASSERT(lbl, clk_s, rst_s, prop, msg)

`define SMB_ASSERT_ALWAYS(lbl, clk_s, prop, msg)

`endif

`endif

FILE: sv/smb_pkg.sv
// types, reset values and the smoothing function of the stereo meter
package smb_pkg;

  typedef logic signed [15:0] level_t;
  typedef logic [15:0]        gain_t;
  typedef logic [7:0]         hold_t;
  typedef logic [14:0]        step_t;
  typedef logic [2:0]         cfg_addr_t;
  typedef logic [15:0]        cfg_data_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_ATTACK_GAIN    = 3'd0,
    CFG_RELEASE_GAIN   = 3'd1,
    CFG_PEAK_FALL_GAIN = 3'd2,
    CFG_HOLD_TICKS     = 3'd3,
    CFG_REDRAW_STEP    = 3'd4
  } cfg_idx_t;

  // configuration register file
  typedef struct packed {
    gain_t attack_gain;
    gain_t release_gain;
    gain_t peak_fall_gain;
    hold_t hold_ticks;
    step_t redraw_step;
  } cfg_regs_t;

  // what one lane hands to the merge stage
  typedef struct packed {
    level_t level;
    level_t peak;
  } lane_state_t;

  // one registered result word
  typedef struct packed {
    level_t left_shown;
    level_t right_shown;
    level_t left_peak_shown;
    level_t right_peak_shown;
    logic   redraw;
  } shown_t;

  localparam level_t LEVEL_FLOOR = 16'sh8000;

  localparam gain_t ATTACK_GAIN_RST    = 16'd39322;
  localparam gain_t RELEASE_GAIN_RST   = 16'd3277;
  localparam gain_t PEAK_FALL_GAIN_RST = 16'd1311;
  localparam hold_t HOLD_TICKS_RST     = 8'd30;
  localparam step_t REDRAW_STEP_RST    = 15'd26;

  // cur + floor((tgt - cur) * gain / 2^16); the result always lies between cur and tgt
  function automatic level_t approach(level_t cur, level_t tgt, gain_t gain);
    logic signed [16:0] diff;
    logic signed [33:0] prod;
    logic signed [17:0] step;
    logic signed [17:0] sum;
    diff = $signed({tgt[15], tgt}) - $signed({cur[15], cur});
    prod = diff * $signed({1'b0, gain});
    step = prod[33:16];
    sum  = $signed({{2{cur[15]}}, cur}) + step;
    return sum[15:0];
  endfunction

endpackage

FILE: sv/smb_in_if.sv
// tick word channel: targets for both channels
interface smb_in_if;
  logic            valid;
  logic            ready;
  smb_pkg::level_t left_target;
  smb_pkg::level_t right_target;
  smb_pkg::level_t left_peak_target;
  smb_pkg::level_t right_peak_target;

  modport source (
    output valid, left_target, right_target, left_peak_target, right_peak_target,
    input  ready
  );
  modport sink (
    input  valid, left_target, right_target, left_peak_target, right_peak_target,
    output ready
  );
endinterface

FILE: sv/smb_out_if.sv
// result word channel: shown levels, peaks and redraw flag
interface smb_out_if;
  logic            valid;
  logic            ready;
  smb_pkg::level_t left_shown;
  smb_pkg::level_t right_shown;
  smb_pkg::level_t left_peak_shown;
  smb_pkg::level_t right_peak_shown;
  logic            redraw;

  modport source (
    output valid, left_shown, right_shown, left_peak_shown, right_peak_shown, redraw,
    input  ready
  );
  modport sink (
    input  valid, left_shown, right_shown, left_peak_shown, right_peak_shown, redraw,
    output ready
  );
endinterface

FILE: sv/smb_cfg_if.sv
// configuration write channel
interface smb_cfg_if;
  logic                 valid;
  logic                 ready;
  smb_pkg::cfg_addr_t   index;
  smb_pkg::cfg_data_t   data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

FILE: sv/stereo_meter_ballistics_peak_hold_top.sv
// top level of the stereo meter ballistics and peak hold block
//
//   channel  | ports   | direction | carries
//   ---------+---------+-----------+------------------------------------------
//   tick     | in_ch   | sink      | level and peak targets, left and right
//   result   | out_ch  | source    | shown levels, shown peaks, redraw flag
//   config   | cfg_ch  | sink      | register index and write data
//
// One word per cycle sustained while out_ch is ready. The accept edge loads both
// lanes (one multiply-add per level, one per peak); the edge on which the merge
// stage advances merges the lanes into the redraw decision and loads the result
// register, whose word is then offered at out_ch.
// Reset (rst_n low, synchronous) puts levels, peaks and drawn levels at the floor.
// A stalled result holds the merge stage; one more word may still sit in the lanes.
module stereo_meter_ballistics_peak_hold_top (
  input  logic          clk,
  input  logic          rst_n,
  smb_in_if.sink        in_ch,
  smb_out_if.source     out_ch,
  smb_cfg_if.sink       cfg_ch
);

  `include "stereo_meter_ballistics_peak_hold_top_assert.svh"

  smb_pkg::cfg_regs_t   cfg_r, cfg_nxt;
  smb_pkg::lane_state_t left_st, right_st;
  smb_pkg::shown_t      shown;
  logic                 s1_valid_r, s1_valid_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 in_acc;
  logic                 s1_adv;

  // configuration writes, always taken
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        smb_pkg::CFG_ATTACK_GAIN:    cfg_nxt.attack_gain    = cfg_ch.data;
        smb_pkg::CFG_RELEASE_GAIN:   cfg_nxt.release_gain   = cfg_ch.data;
        smb_pkg::CFG_PEAK_FALL_GAIN: cfg_nxt.peak_fall_gain = cfg_ch.data;
        smb_pkg::CFG_HOLD_TICKS:     cfg_nxt.hold_ticks     = cfg_ch.data[7:0];
        smb_pkg::CFG_REDRAW_STEP:    cfg_nxt.redraw_step    = cfg_ch.data[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_gain    <= smb_pkg::ATTACK_GAIN_RST;
      cfg_r.release_gain   <= smb_pkg::RELEASE_GAIN_RST;
      cfg_r.peak_fall_gain <= smb_pkg::PEAK_FALL_GAIN_RST;
      cfg_r.hold_ticks     <= smb_pkg::HOLD_TICKS_RST;
      cfg_r.redraw_step    <= smb_pkg::REDRAW_STEP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // pipeline flow: lanes hold one word, the result register another
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_adv ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // channel lanes
  smb_lane u_lane_left (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_acc),
    .target      (in_ch.left_target),
    .peak_target (in_ch.left_peak_target),
    .cfg         (cfg_r),
    .st          (left_st)
  );

  smb_lane u_lane_right (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_acc),
    .target      (in_ch.right_target),
    .peak_target (in_ch.right_peak_target),
    .cfg         (cfg_r),
    .st          (right_st)
  );

  // merge stage and result register
  smb_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (s1_adv),
    .left        (left_st),
    .right       (right_st),
    .redraw_step (cfg_r.redraw_step),
    .shown       (shown)
  );

  assign out_ch.valid            = out_valid_r;
  assign out_ch.left_shown       = shown.left_shown;
  assign out_ch.right_shown      = shown.right_shown;
  assign out_ch.left_peak_shown  = shown.left_peak_shown;
  assign out_ch.right_peak_shown = shown.right_peak_shown;
  assign out_ch.redraw           = shown.redraw;

  // checks
  `SMB_ASSERT(a_acc_fills_lanes, clk, rst_n, in_acc |=> s1_valid_r,
              "accepted word not in lanes")
  `SMB_ASSERT(a_stall_holds_merge, clk, rst_n, (out_valid_r && !out_ch.ready) |-> !s1_adv,
              "merge advanced into a stalled result")
  `SMB_ASSERT(a_adv_gives_result, clk, rst_n, s1_adv |=> out_valid_r,
              "merged word not shown")
  `SMB_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> (!s1_valid_r && !out_valid_r),
                     "pipeline not empty after reset")

endmodule

FILE: sv/smb_lane.sv
// one channel lane: level smoothing plus peak capture, hold and decay
module smb_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  smb_pkg::level_t     target,
  input  smb_pkg::level_t     peak_target,
  input  smb_pkg::cfg_regs_t  cfg,
  output smb_pkg::lane_state_t st
);

  smb_pkg::level_t level_r, level_nxt;
  smb_pkg::level_t peak_r, peak_nxt;
  smb_pkg::hold_t  hold_r, hold_nxt;
  smb_pkg::gain_t  level_gain;

  // attack when the target is above the level, release otherwise
  always_comb begin
    level_gain = (target > level_r) ? cfg.attack_gain : cfg.release_gain;
    level_nxt  = smb_pkg::approach(level_r, target, level_gain);
  end

  // peak capture, hold countdown, then decay toward the target
  always_comb begin
    peak_nxt = peak_r;
    hold_nxt = hold_r;
    priority if (peak_target > peak_r) begin
      peak_nxt = peak_target;
      hold_nxt = cfg.hold_ticks;
    end else if (hold_r != '0) begin
      hold_nxt = hold_r - 8'd1;
    end else begin
      peak_nxt = smb_pkg::approach(peak_r, peak_target, cfg.peak_fall_gain);
    end
  end

  // lane state advances once per accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= smb_pkg::LEVEL_FLOOR;
      peak_r  <= smb_pkg::LEVEL_FLOOR;
      hold_r  <= '0;
    end else if (accept) begin
      level_r <= level_nxt;
      peak_r  <= peak_nxt;
      hold_r  <= hold_nxt;
    end
  end

  assign st.level = level_r;
  assign st.peak  = peak_r;

endmodule

FILE: sv/smb_merge.sv
// merge stage: redraw decision across both lanes, last-drawn levels, result register
module smb_merge (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  smb_pkg::lane_state_t left,
  input  smb_pkg::lane_state_t right,
  input  smb_pkg::step_t       redraw_step,
  output smb_pkg::shown_t      shown
);

  smb_pkg::level_t left_drawn_r, left_drawn_nxt;
  smb_pkg::level_t right_drawn_r, right_drawn_nxt;
  smb_pkg::shown_t shown_r, shown_nxt;
  logic [16:0]     left_dist;
  logic [16:0]     right_dist;
  logic            redraw;

  // distance of each level from what was last drawn
  function automatic logic [16:0] abs_diff(smb_pkg::level_t a, smb_pkg::level_t b);
    logic signed [16:0] d;
    d = $signed({a[15], a}) - $signed({b[15], b});
    return d[16] ? 17'(-d) : 17'(d);
  endfunction

  always_comb begin
    left_dist  = abs_diff(left.level, left_drawn_r);
    right_dist = abs_diff(right.level, right_drawn_r);
    redraw     = (left_dist > {2'b00, redraw_step}) || (right_dist > {2'b00, redraw_step});
    left_drawn_nxt  = redraw ? left.level  : left_drawn_r;
    right_drawn_nxt = redraw ? right.level : right_drawn_r;
    shown_nxt.left_shown       = left.level;
    shown_nxt.right_shown      = right.level;
    shown_nxt.left_peak_shown  = left.peak;
    shown_nxt.right_peak_shown = right.peak;
    shown_nxt.redraw           = redraw;
  end

  // last-drawn levels are state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_drawn_r  <= smb_pkg::LEVEL_FLOOR;
      right_drawn_r <= smb_pkg::LEVEL_FLOOR;
    end else if (load) begin
      left_drawn_r  <= left_drawn_nxt;
      right_drawn_r <= right_drawn_nxt;
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (load) begin
      shown_r <= shown_nxt;
    end
  end

  assign shown = shown_r;

endmodule
